/* rtl/core/gaps_pkg.sv */
package gaps_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_GRID     = 64;
    localparam int COST_W       = 26;
    localparam int CNT_W        = 13;

    localparam logic [13:0] STEP_STRAIGHT = 14'd10000;
    localparam logic [13:0] STEP_DIAG     = 14'd14142;
    localparam logic [13:0] DIAG_EXTRA    = 14'd4142;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] STAT_NONE    = 2'd0;
    localparam logic [1:0] STAT_GOAL    = 2'd1;
    localparam logic [1:0] STAT_PARTIAL = 2'd2;

    localparam logic [1:0] REG_COLS   = 2'd0;
    localparam logic [1:0] REG_ROWS   = 2'd1;
    localparam logic [1:0] REG_BUDGET = 2'd2;

    typedef enum logic [4:0] {
        S_CLR_MAP, S_IDLE, S_CHK, S_CLR_NODE, S_INIT, S_LOOP, S_SCAN, S_EXPAND,
        S_NBO, S_NBR, S_NBU, S_FIN, S_PCR, S_PCW, S_PSR, S_PSW, S_WP, S_RESPOND
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  tile_x;
        logic [5:0]  tile_y;
        logic        tile_open;
        logic [5:0]  start_col;
        logic [5:0]  start_row;
        logic [5:0]  goal_col;
        logic [5:0]  goal_row;
        logic [11:0] waypoint_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  search_status;
        logic [12:0] path_length;
        logic [12:0] tiles_expanded;
        logic [5:0]  waypoint_col;
        logic [5:0]  waypoint_row;
        logic        index_invalid;
    } out_word_t;

    typedef struct packed {
        logic              seen;
        logic              closed;
        logic [2:0]        par;
        logic [COST_W-1:0] cost;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    // Octile distance: 14142 * min + 10000 * (max - min) = 4142 * min + 10000 * max.
    function automatic logic [COST_W-1:0] octile(input logic [7:0] x, input logic [7:0] y,
                                                 input logic [7:0] gx, input logic [7:0] gy);
        logic [7:0] dx;
        logic [7:0] dy;
        logic [7:0] lo;
        logic [7:0] hi;
        dx = (x > gx) ? x - gx : gx - x;
        dy = (y > gy) ? y - gy : gy - y;
        lo = (dx < dy) ? dx : dy;
        hi = (dx < dy) ? dy : dx;
        return (COST_W'(lo) * COST_W'(DIAG_EXTRA)) + (COST_W'(hi) * COST_W'(STEP_STRAIGHT));
    endfunction

    // Direction codes run over (dx, dy) with dx outermost, skipping (0, 0).
    function automatic logic step_left(input logic [2:0] d);
        return d <= 3'd2;
    endfunction

    function automatic logic step_right(input logic [2:0] d);
        return d >= 3'd5;
    endfunction

    function automatic logic step_up(input logic [2:0] d);
        return (d == 3'd0) || (d == 3'd3) || (d == 3'd5);
    endfunction

    function automatic logic step_down(input logic [2:0] d);
        return (d == 3'd2) || (d == 3'd4) || (d == 3'd7);
    endfunction

endpackage

/* rtl/core/gaps_ram.sv */
module gaps_ram #(
    parameter int W  = 1,
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [(1 << AW)];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/grid_astar_path_search_unit.sv */
// Grid path search unit. Each input word carries a command and gives exactly one result
// word. A tile load writes one passable bit; a waypoint read goes through the path
// memory, which has a registered read. A search runs 8-neighbour A* with an octile
// heuristic over the configured grid: once the request passes its checks it first clears
// the node memory, one entry a cycle (MAX_COLS rounded up to a power of two times
// MAX_ROWS rounded likewise entries), then for each expanded tile scans every grid tile
// through the node memory port to find the open tile of smallest (g + h, column, row),
// followed by neighbour relaxation; the path is then walked back twice. After reset the
// tile map is swept to blocked, one entry a cycle over the same number of entries, and
// no input word is taken until that sweep ends; configuration writes are taken at any
// time. A finished result waits in an output register, and the next word is accepted
// once the unit is back at idle.
module grid_astar_path_search_unit #(
    parameter int MAX_COLS = gaps_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gaps_pkg::DEF_MAX_ROWS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gaps_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gaps_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = CW + RW;
    localparam int IW = (AW > 13) ? AW : 13;
    localparam int RST_COLS = (gaps_pkg::DEF_GRID < MAX_COLS) ? gaps_pkg::DEF_GRID : MAX_COLS;
    localparam int RST_ROWS = (gaps_pkg::DEF_GRID < MAX_ROWS) ? gaps_pkg::DEF_GRID : MAX_ROWS;

    gaps_pkg::state_t state_reg, state_next;

    // Configuration, held as the last usable column and row.
    logic [CW-1:0] cols_m1_reg;
    logic [RW-1:0] rows_m1_reg;
    logic [12:0]   budget_reg;

    gaps_pkg::in_word_t in_reg;
    logic [AW-1:0] clr_cnt_reg;

    // Search state.
    logic [12:0]   count_reg;
    logic [12:0]   len_reg;
    logic [AW-1:0] best_reg;
    logic [gaps_pkg::COST_W-1:0] best_est_reg;
    logic          found_reg;

    // Scan pipeline and running minimum.
    logic [CW-1:0] scan_x_reg;
    logic [RW-1:0] scan_y_reg;
    logic          issue_done_reg;
    logic          v_s1_reg;
    logic          last_s1_reg;
    logic [AW-1:0] addr_s1_reg;
    logic [gaps_pkg::COST_W-1:0] h_s1_reg;
    logic          have_reg;
    logic [gaps_pkg::COST_W:0] bf_reg;
    logic [AW-1:0] cur_reg;
    logic [gaps_pkg::COST_W-1:0] cur_cost_reg;
    logic [2:0]    cur_par_reg;
    logic [gaps_pkg::COST_W-1:0] cur_h_reg;

    // Neighbour handling.
    logic [3:0]    nbk_reg;
    logic          nbv_reg;
    logic [2:0]    nbk_s1_reg;
    logic          inb_s1_reg;
    logic [7:0]    nb_ok_reg;
    logic [2:0]    dir_reg;

    // Path walk.
    logic [AW-1:0] walk_reg;
    logic [AW-1:0] tgt_reg;
    logic [12:0]   n_reg;
    logic [12:0]   k_reg;

    // Result fields.
    logic [1:0]    res_status_reg;
    logic [5:0]    res_wc_reg;
    logic [5:0]    res_wr_reg;
    logic          res_inv_reg;
    logic          m_valid_reg;
    gaps_pkg::out_word_t m_data_reg;

    // Memory ports.
    logic          map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    logic          map_wdata, map_rdata;
    logic          node_we;
    logic [AW-1:0] node_waddr, node_raddr;
    gaps_pkg::node_t node_wdata, node_rd;
    logic [gaps_pkg::NODE_W-1:0] node_rdata;
    logic          path_we;
    logic [AW-1:0] path_waddr, path_raddr, path_rdata;

    gaps_ram #(.W(1), .AW(AW)) u_map (
        .aclk(aclk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
        .raddr(map_raddr), .rdata(map_rdata)
    );

    gaps_ram #(.W(gaps_pkg::NODE_W), .AW(AW)) u_node (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rdata)
    );

    gaps_ram #(.W(AW), .AW(AW)) u_path (
        .aclk(aclk), .we(path_we), .waddr(path_waddr), .wdata(walk_reg),
        .raddr(path_raddr), .rdata(path_rdata)
    );

    assign node_rd = gaps_pkg::node_t'(node_rdata);

    // Tile addresses are {row, column}.
    logic [AW-1:0] start_addr, goal_addr;
    logic          start_in, goal_in, load_in;
    assign start_addr = {RW'(in_reg.start_row), CW'(in_reg.start_col)};
    assign goal_addr  = {RW'(in_reg.goal_row), CW'(in_reg.goal_col)};
    assign start_in   = (9'(in_reg.start_col) <= 9'(cols_m1_reg)) &&
                        (9'(in_reg.start_row) <= 9'(rows_m1_reg));
    assign goal_in    = (9'(in_reg.goal_col) <= 9'(cols_m1_reg)) &&
                        (9'(in_reg.goal_row) <= 9'(rows_m1_reg));
    assign load_in    = (9'(s_data.tile_x) < 9'(MAX_COLS)) && (9'(s_data.tile_y) < 9'(MAX_ROWS));

    // Neighbours of the tile being expanded, with their grid bounds.
    logic [CW-1:0] cur_x;
    logic [RW-1:0] cur_y;
    logic [7:0]    nb_in;
    logic [AW-1:0] nb_addr [8];
    assign cur_x = cur_reg[CW-1:0];
    assign cur_y = cur_reg[AW-1:CW];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            logic [2:0]    dj;
            logic          okx, oky;
            logic [CW-1:0] nx;
            logic [RW-1:0] ny;
            dj  = 3'(j);
            okx = 1'b1;
            oky = 1'b1;
            nx  = cur_x;
            ny  = cur_y;
            if (gaps_pkg::step_left(dj)) begin
                okx = (cur_x != '0);
                nx  = cur_x - CW'(1);
            end else if (gaps_pkg::step_right(dj)) begin
                okx = (cur_x < cols_m1_reg);
                nx  = cur_x + CW'(1);
            end
            if (gaps_pkg::step_up(dj)) begin
                oky = (cur_y != '0);
                ny  = cur_y - RW'(1);
            end else if (gaps_pkg::step_down(dj)) begin
                oky = (cur_y < rows_m1_reg);
                ny  = cur_y + RW'(1);
            end
            nb_in[j]   = okx && oky;
            nb_addr[j] = {ny, nx};
        end
    end

    // A diagonal step needs both orthogonal tiles passable.
    logic dir_pass;
    always_comb begin
        logic [2:0] hi_idx, vi_idx;
        hi_idx   = gaps_pkg::step_left(dir_reg) ? 3'd1 : 3'd6;
        vi_idx   = gaps_pkg::step_up(dir_reg) ? 3'd3 : 3'd4;
        dir_pass = nb_ok_reg[dir_reg];
        if ((gaps_pkg::step_left(dir_reg) || gaps_pkg::step_right(dir_reg)) &&
            (gaps_pkg::step_up(dir_reg) || gaps_pkg::step_down(dir_reg))) begin
            dir_pass = dir_pass && nb_ok_reg[hi_idx] && nb_ok_reg[vi_idx];
        end
    end

    // New cost of the neighbour in hand.
    logic [gaps_pkg::COST_W-1:0] new_cost;
    logic                        dir_diag;
    assign dir_diag = (gaps_pkg::step_left(dir_reg) || gaps_pkg::step_right(dir_reg)) &&
                      (gaps_pkg::step_up(dir_reg) || gaps_pkg::step_down(dir_reg));
    assign new_cost = cur_cost_reg + gaps_pkg::COST_W'(dir_diag ? gaps_pkg::STEP_DIAG
                                                                : gaps_pkg::STEP_STRAIGHT);

    // Step from a tile back to its parent along the stored direction.
    logic [AW-1:0] walk_pred;
    always_comb begin
        logic [CW-1:0] wx;
        logic [RW-1:0] wy;
        wx = walk_reg[CW-1:0];
        wy = walk_reg[AW-1:CW];
        if (gaps_pkg::step_left(node_rd.par)) begin
            wx = wx + CW'(1);
        end else if (gaps_pkg::step_right(node_rd.par)) begin
            wx = wx - CW'(1);
        end
        if (gaps_pkg::step_up(node_rd.par)) begin
            wy = wy + RW'(1);
        end else if (gaps_pkg::step_down(node_rd.par)) begin
            wy = wy - RW'(1);
        end
        walk_pred = {wy, wx};
    end

    logic [IW-1:0] wp_idx_w, k_m1_w;
    assign wp_idx_w = IW'(s_data.waypoint_index);
    assign k_m1_w   = IW'(k_reg - 13'd1);

    logic [gaps_pkg::COST_W:0] scan_f;
    assign scan_f = {1'b0, node_rd.cost} + {1'b0, h_s1_reg};

    // Next state and memory port control.
    always_comb begin
        state_next = state_reg;
        map_we     = 1'b0;
        map_waddr  = clr_cnt_reg;
        map_wdata  = 1'b0;
        map_raddr  = goal_addr;
        node_we    = 1'b0;
        node_waddr = clr_cnt_reg;
        node_wdata = '0;
        node_raddr = walk_reg;
        path_we    = 1'b0;
        path_waddr = k_m1_w[AW-1:0];
        path_raddr = wp_idx_w[AW-1:0];
        case (state_reg)
            gaps_pkg::S_CLR_MAP: begin
                map_we = 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = gaps_pkg::S_IDLE;
                end
            end
            gaps_pkg::S_IDLE: begin
                map_raddr = {RW'(s_data.goal_row), CW'(s_data.goal_col)};
                if (s_valid) begin
                    case (s_data.command)
                        gaps_pkg::CMD_LOAD: begin
                            map_we     = load_in;
                            map_waddr  = {RW'(s_data.tile_y), CW'(s_data.tile_x)};
                            map_wdata  = s_data.tile_open;
                            state_next = gaps_pkg::S_RESPOND;
                        end
                        gaps_pkg::CMD_SEARCH: state_next = gaps_pkg::S_CHK;
                        gaps_pkg::CMD_READ:   state_next = gaps_pkg::S_WP;
                        default:              state_next = gaps_pkg::S_RESPOND;
                    endcase
                end
            end
            gaps_pkg::S_CHK: begin
                if ((start_addr == goal_addr && start_in) || !goal_in || !map_rdata ||
                    !start_in) begin
                    state_next = gaps_pkg::S_RESPOND;
                end else begin
                    state_next = gaps_pkg::S_CLR_NODE;
                end
            end
            gaps_pkg::S_CLR_NODE: begin
                node_we = 1'b1;
                if (&clr_cnt_reg) begin
                    state_next = gaps_pkg::S_INIT;
                end
            end
            gaps_pkg::S_INIT: begin
                node_we         = 1'b1;
                node_waddr      = start_addr;
                node_wdata.seen = 1'b1;
                state_next      = gaps_pkg::S_LOOP;
            end
            gaps_pkg::S_LOOP: begin
                state_next = (count_reg < budget_reg) ? gaps_pkg::S_SCAN : gaps_pkg::S_FIN;
            end
            gaps_pkg::S_SCAN: begin
                node_raddr = {scan_y_reg, scan_x_reg};
                if (v_s1_reg && last_s1_reg) begin
                    state_next = gaps_pkg::S_EXPAND;
                end
            end
            gaps_pkg::S_EXPAND: begin
                if (!have_reg) begin
                    state_next = gaps_pkg::S_FIN;
                end else begin
                    node_we           = 1'b1;
                    node_waddr        = cur_reg;
                    node_wdata.seen   = 1'b1;
                    node_wdata.closed = 1'b1;
                    node_wdata.par    = cur_par_reg;
                    node_wdata.cost   = cur_cost_reg;
                    state_next = (cur_reg == goal_addr) ? gaps_pkg::S_FIN : gaps_pkg::S_NBO;
                end
            end
            gaps_pkg::S_NBO: begin
                map_raddr = nb_addr[nbk_reg[2:0]];
                if (nbv_reg && nbk_s1_reg == 3'd7) begin
                    state_next = gaps_pkg::S_NBR;
                end
            end
            gaps_pkg::S_NBR: begin
                node_raddr = nb_addr[dir_reg];
                if (dir_pass) begin
                    state_next = gaps_pkg::S_NBU;
                end else if (dir_reg == 3'd7) begin
                    state_next = gaps_pkg::S_LOOP;
                end
            end
            gaps_pkg::S_NBU: begin
                if (!node_rd.seen || new_cost < node_rd.cost) begin
                    node_we           = 1'b1;
                    node_waddr        = nb_addr[dir_reg];
                    node_wdata.seen   = 1'b1;
                    node_wdata.closed = node_rd.closed;
                    node_wdata.par    = dir_reg;
                    node_wdata.cost   = new_cost;
                end
                state_next = (dir_reg == 3'd7) ? gaps_pkg::S_LOOP : gaps_pkg::S_NBR;
            end
            gaps_pkg::S_FIN: begin
                if (!found_reg && best_reg == start_addr) begin
                    state_next = gaps_pkg::S_RESPOND;
                end else begin
                    state_next = gaps_pkg::S_PCR;
                end
            end
            gaps_pkg::S_PCR: begin
                state_next = (walk_reg == start_addr) ? gaps_pkg::S_PSR : gaps_pkg::S_PCW;
            end
            gaps_pkg::S_PCW: state_next = gaps_pkg::S_PCR;
            gaps_pkg::S_PSR: begin
                state_next = (k_reg == '0) ? gaps_pkg::S_RESPOND : gaps_pkg::S_PSW;
            end
            gaps_pkg::S_PSW: begin
                path_we    = 1'b1;
                state_next = gaps_pkg::S_PSR;
            end
            gaps_pkg::S_WP: state_next = gaps_pkg::S_RESPOND;
            gaps_pkg::S_RESPOND: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = gaps_pkg::S_IDLE;
                end
            end
            default: state_next = gaps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gaps_pkg::S_CLR_MAP;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers; dimensions are clamped into 1..MAX.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_m1_reg <= CW'(RST_COLS - 1);
            rows_m1_reg <= RW'(RST_ROWS - 1);
            budget_reg  <= 13'd4096;
        end else if (cfg_valid) begin
            case (cfg_index)
                gaps_pkg::REG_COLS: begin
                    if (cfg_data[6:0] == '0) begin
                        cols_m1_reg <= '0;
                    end else if (9'(cfg_data[6:0]) > 9'(MAX_COLS)) begin
                        cols_m1_reg <= CW'(MAX_COLS - 1);
                    end else begin
                        cols_m1_reg <= CW'(cfg_data[6:0] - 7'd1);
                    end
                end
                gaps_pkg::REG_ROWS: begin
                    if (cfg_data[6:0] == '0) begin
                        rows_m1_reg <= '0;
                    end else if (9'(cfg_data[6:0]) > 9'(MAX_ROWS)) begin
                        rows_m1_reg <= RW'(MAX_ROWS - 1);
                    end else begin
                        rows_m1_reg <= RW'(cfg_data[6:0] - 7'd1);
                    end
                end
                gaps_pkg::REG_BUDGET: budget_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            count_reg      <= '0;
            len_reg        <= '0;
            m_valid_reg    <= 1'b0;
            v_s1_reg       <= 1'b0;
            nbv_reg        <= 1'b0;
            have_reg       <= 1'b0;
            found_reg      <= 1'b0;
            issue_done_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                gaps_pkg::S_CLR_MAP, gaps_pkg::S_CLR_NODE: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
                gaps_pkg::S_IDLE: begin
                    if (s_valid) begin
                        in_reg         <= s_data;
                        res_status_reg <= gaps_pkg::STAT_NONE;
                        res_inv_reg    <= 1'b0;
                        res_wc_reg     <= '0;
                        res_wr_reg     <= '0;
                        found_reg      <= 1'b0;
                        if (s_data.command == gaps_pkg::CMD_SEARCH) begin
                            len_reg   <= '0;
                            count_reg <= '0;
                        end
                    end
                end
                gaps_pkg::S_INIT: begin
                    best_reg     <= start_addr;
                    best_est_reg <= gaps_pkg::octile(8'(in_reg.start_col), 8'(in_reg.start_row),
                                                     8'(in_reg.goal_col), 8'(in_reg.goal_row));
                end
                gaps_pkg::S_LOOP: begin
                    scan_x_reg     <= '0;
                    scan_y_reg     <= '0;
                    issue_done_reg <= 1'b0;
                    v_s1_reg       <= 1'b0;
                    have_reg       <= 1'b0;
                end
                gaps_pkg::S_SCAN: begin
                    v_s1_reg <= !issue_done_reg;
                    if (!issue_done_reg) begin
                        addr_s1_reg <= {scan_y_reg, scan_x_reg};
                        h_s1_reg    <= gaps_pkg::octile(8'(scan_x_reg), 8'(scan_y_reg),
                                                        8'(in_reg.goal_col), 8'(in_reg.goal_row));
                        last_s1_reg <= (scan_x_reg == cols_m1_reg) && (scan_y_reg == rows_m1_reg);
                        if (scan_x_reg == cols_m1_reg && scan_y_reg == rows_m1_reg) begin
                            issue_done_reg <= 1'b1;
                        end
                        if (scan_y_reg == rows_m1_reg) begin
                            scan_y_reg <= '0;
                            scan_x_reg <= scan_x_reg + CW'(1);
                        end else begin
                            scan_y_reg <= scan_y_reg + RW'(1);
                        end
                    end
                    // Column-major order with a strict compare keeps the lowest (x, y) on ties.
                    if (v_s1_reg && node_rd.seen && !node_rd.closed &&
                        (!have_reg || scan_f < bf_reg)) begin
                        have_reg     <= 1'b1;
                        bf_reg       <= scan_f;
                        cur_reg      <= addr_s1_reg;
                        cur_cost_reg <= node_rd.cost;
                        cur_par_reg  <= node_rd.par;
                        cur_h_reg    <= h_s1_reg;
                    end
                end
                gaps_pkg::S_EXPAND: begin
                    nbk_reg <= '0;
                    nbv_reg <= 1'b0;
                    dir_reg <= '0;
                    if (have_reg) begin
                        count_reg <= count_reg + 13'd1;
                        if (cur_reg == goal_addr) begin
                            found_reg <= 1'b1;
                        end else if (cur_h_reg < best_est_reg) begin
                            best_est_reg <= cur_h_reg;
                            best_reg     <= cur_reg;
                        end
                    end
                end
                gaps_pkg::S_NBO: begin
                    nbv_reg <= !nbk_reg[3];
                    if (!nbk_reg[3]) begin
                        nbk_s1_reg <= nbk_reg[2:0];
                        inb_s1_reg <= nb_in[nbk_reg[2:0]];
                        nbk_reg    <= nbk_reg + 4'd1;
                    end
                    if (nbv_reg) begin
                        nb_ok_reg[nbk_s1_reg] <= inb_s1_reg && map_rdata;
                    end
                end
                gaps_pkg::S_NBR: begin
                    if (!dir_pass) begin
                        dir_reg <= dir_reg + 3'd1;
                    end
                end
                gaps_pkg::S_NBU: dir_reg <= dir_reg + 3'd1;
                gaps_pkg::S_FIN: begin
                    walk_reg <= found_reg ? goal_addr : best_reg;
                    tgt_reg  <= found_reg ? goal_addr : best_reg;
                    n_reg    <= '0;
                    if (found_reg) begin
                        res_status_reg <= gaps_pkg::STAT_GOAL;
                    end else if (best_reg != start_addr) begin
                        res_status_reg <= gaps_pkg::STAT_PARTIAL;
                    end
                end
                gaps_pkg::S_PCR: begin
                    if (walk_reg == start_addr) begin
                        k_reg    <= n_reg;
                        walk_reg <= tgt_reg;
                    end
                end
                gaps_pkg::S_PCW: begin
                    walk_reg <= walk_pred;
                    n_reg    <= n_reg + 13'd1;
                end
                gaps_pkg::S_PSR: begin
                    if (k_reg == '0) begin
                        len_reg <= n_reg;
                    end
                end
                gaps_pkg::S_PSW: begin
                    walk_reg <= walk_pred;
                    k_reg    <= k_reg - 13'd1;
                end
                gaps_pkg::S_WP: begin
                    if ({1'b0, in_reg.waypoint_index} >= len_reg) begin
                        res_inv_reg <= 1'b1;
                    end else begin
                        res_wc_reg <= 6'(path_rdata[CW-1:0]);
                        res_wr_reg <= 6'(path_rdata[AW-1:CW]);
                    end
                end
                gaps_pkg::S_RESPOND: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                 <= 1'b1;
                        m_data_reg.search_status  <= res_status_reg;
                        m_data_reg.path_length    <= len_reg;
                        m_data_reg.tiles_expanded <= count_reg;
                        m_data_reg.waypoint_col   <= res_wc_reg;
                        m_data_reg.waypoint_row   <= res_wr_reg;
                        m_data_reg.index_invalid  <= res_inv_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_ready   = (state_reg == gaps_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

`ifndef NO_ASSERTIONS
    // A stored path never holds more steps than tiles the search expanded.
    a_len_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= count_reg)
        else $error("path length exceeds expanded tile count");

    // An invalid waypoint index reports a zero waypoint.
    a_inv_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.index_invalid |-> m_data.waypoint_col == '0 &&
        m_data.waypoint_row == '0)
        else $error("invalid waypoint carries coordinates");

    // A search result never flags an invalid index.
    a_status_inv: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.search_status != gaps_pkg::STAT_NONE |-> !m_data.index_invalid)
        else $error("search result flags invalid index");

    // Reaching the goal always leaves at least one waypoint.
    a_goal_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.search_status == gaps_pkg::STAT_GOAL |-> m_data.path_length != '0)
        else $error("goal reached with empty path");
`endif

endmodule

/* tb/path_search_checker.sv */
module path_search_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  gaps_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  gaps_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    output int                  fail_count,
    output int                  pending,
    output int                  n_goal,
    output int                  n_partial,
    output int                  n_nopath,
    output int                  n_words
);

    localparam int GRID_W = 64;
    localparam int CELLS  = 4096;
    localparam int DX[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    localparam int DY[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};

    bit          tile_pass[CELLS];
    int unsigned g_cost[CELLS];
    bit          seen[CELLS];
    bit          closed[CELLS];
    bit [2:0]    came_from[CELLS];
    int unsigned route[CELLS];
    int unsigned cols_q, rows_q, budget_q;
    int unsigned best_tile, best_h, expanded_q, route_len;
    gaps_pkg::out_word_t result_q[$];

    function automatic bit passable(int x, int y);
        if (x < 0 || y < 0 || x >= int'(cols_q) || y >= int'(rows_q)) return 0;
        return tile_pass[y * GRID_W + x];
    endfunction

    function automatic int unsigned tile_dist(int unsigned x, int unsigned y,
                                              int unsigned gx, int unsigned gy);
        int unsigned ddx, ddy, lo, hi;
        ddx = x > gx ? x - gx : gx - x;
        ddy = y > gy ? y - gy : gy - y;
        lo = ddx < ddy ? ddx : ddy;
        hi = ddx < ddy ? ddy : ddx;
        return 14142 * lo + 10000 * (hi - lo);
    endfunction

    // A* as the block does it: a full scan picks the open tile of least (f, column, row).
    function automatic logic [1:0] run_search(int unsigned sx, int unsigned sy,
                                              int unsigned gx, int unsigned gy);
        bit found, have, diag;
        int unsigned start, target, n, c, bx, by, bf, f, cur, cg, hc, nc, ni, d;
        int nx, ny;
        found = 0;
        start = sy * GRID_W + sx;
        route_len = 0;
        expanded_q = 0;
        if ((sx == gx && sy == gy) || !passable(gx, gy) || sx >= cols_q || sy >= rows_q)
            return gaps_pkg::STAT_NONE;
        foreach (seen[i]) begin
            seen[i] = 0;
            closed[i] = 0;
        end
        seen[start] = 1;
        g_cost[start] = 0;
        best_tile = start;
        best_h = tile_dist(sx, sy, gx, gy);
        while (expanded_q < budget_q) begin
            have = 0;
            bx = 0;
            by = 0;
            bf = 0;
            for (int unsigned x = 0; x < cols_q; x++)
                for (int unsigned y = 0; y < rows_q; y++) begin
                    if (seen[y * GRID_W + x] && !closed[y * GRID_W + x]) begin
                        f = g_cost[y * GRID_W + x] + tile_dist(x, y, gx, gy);
                        if (!have || f < bf) begin
                            have = 1;
                            bf = f;
                            bx = x;
                            by = y;
                        end
                    end
                end
            if (!have) break;
            cur = by * GRID_W + bx;
            closed[cur] = 1;
            expanded_q++;
            if (bx == gx && by == gy) begin
                found = 1;
                break;
            end
            hc = tile_dist(bx, by, gx, gy);
            if (hc < best_h) begin
                best_h = hc;
                best_tile = cur;
            end
            cg = g_cost[cur];
            for (d = 0; d < 8; d++) begin
                nx = int'(bx) + DX[d];
                ny = int'(by) + DY[d];
                diag = DX[d] != 0 && DY[d] != 0;
                if (!passable(nx, ny)) continue;
                if (diag && !(passable(nx, by) && passable(bx, ny))) continue;
                nc = cg + (diag ? 14142 : 10000);
                ni = ny * GRID_W + nx;
                if (!seen[ni] || nc < g_cost[ni]) begin
                    seen[ni] = 1;
                    g_cost[ni] = nc;
                    came_from[ni] = 3'(d);
                end
            end
        end
        if (found) target = gy * GRID_W + gx;
        else if (best_tile == start) return gaps_pkg::STAT_NONE;
        else target = best_tile;
        n = 0;
        c = target;
        while (c != start && n < CELLS) begin
            d = came_from[c];
            n++;
            c = (c / GRID_W - DY[d]) * GRID_W + (c % GRID_W - DX[d]);
        end
        c = target;
        for (int unsigned k = n; k > 0; k--) begin
            d = came_from[c];
            route[k - 1] = c;
            c = (c / GRID_W - DY[d]) * GRID_W + (c % GRID_W - DX[d]);
        end
        route_len = n;
        return found ? gaps_pkg::STAT_GOAL : gaps_pkg::STAT_PARTIAL;
    endfunction

    function automatic gaps_pkg::out_word_t predict_result(gaps_pkg::in_word_t w);
        gaps_pkg::out_word_t r;
        r = '0;
        case (w.command)
            gaps_pkg::CMD_LOAD: tile_pass[w.tile_y * GRID_W + w.tile_x] = w.tile_open;
            gaps_pkg::CMD_SEARCH: begin
                r.search_status = run_search(w.start_col, w.start_row, w.goal_col, w.goal_row);
                case (r.search_status)
                    gaps_pkg::STAT_GOAL:    n_goal++;
                    gaps_pkg::STAT_PARTIAL: n_partial++;
                    default:                n_nopath++;
                endcase
            end
            gaps_pkg::CMD_READ: begin
                if (w.waypoint_index < route_len) begin
                    r.waypoint_col = 6'(route[w.waypoint_index] % GRID_W);
                    r.waypoint_row = 6'(route[w.waypoint_index] / GRID_W);
                end else begin
                    r.index_invalid = 1'b1;
                end
            end
            default: ;
        endcase
        r.path_length    = 13'(route_len);
        r.tiles_expanded = 13'(expanded_q);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    task automatic compare_word(gaps_pkg::out_word_t got, gaps_pkg::out_word_t want);
        if (got.search_status != want.search_status)
            report_mismatch("search_status", got.search_status, want.search_status);
        if (got.path_length != want.path_length)
            report_mismatch("path_length", got.path_length, want.path_length);
        if (got.tiles_expanded != want.tiles_expanded)
            report_mismatch("tiles_expanded", got.tiles_expanded, want.tiles_expanded);
        if (got.waypoint_col != want.waypoint_col)
            report_mismatch("waypoint_col", got.waypoint_col, want.waypoint_col);
        if (got.waypoint_row != want.waypoint_row)
            report_mismatch("waypoint_row", got.waypoint_row, want.waypoint_row);
        if (got.index_invalid != want.index_invalid)
            report_mismatch("index_invalid", got.index_invalid, want.index_invalid);
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        n_goal = 0;
        n_partial = 0;
        n_nopath = 0;
        n_words = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cols_q = 64;
            rows_q = 64;
            budget_q = 4096;
            foreach (tile_pass[i]) tile_pass[i] = 0;
            best_tile = 0;
            best_h = 0;
            expanded_q = 0;
            route_len = 0;
            result_q.delete();
        end else begin
            // Results are taken first: one cannot leave in the cycle its word arrives.
            if (m_valid && m_ready) begin
                n_words++;
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result word", 1, 0);
                end else begin
                    compare_word(m_data, result_q.pop_front());
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gaps_pkg::REG_COLS:   cols_q = cfg_data[6:0] < 1 ? 1 :
                                                   cfg_data[6:0] > 64 ? 64 : cfg_data[6:0];
                    gaps_pkg::REG_ROWS:   rows_q = cfg_data[6:0] < 1 ? 1 :
                                                   cfg_data[6:0] > 64 ? 64 : cfg_data[6:0];
                    gaps_pkg::REG_BUDGET: budget_q = 32'(cfg_data);
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                result_q.insert(result_q.size(), predict_result(s_data));
        end
        pending = result_q.size();
    end

endmodule

/* tb/tb_top.sv */
module tb_top;

    // The command field has a fourth code that the block must answer without effect.
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    gaps_pkg::in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    gaps_pkg::out_word_t m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    int fail_count, pending, n_goal, n_partial, n_nopath, n_words;
    int idle_pct, stall_pct;

    grid_astar_path_search_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    path_search_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .n_goal(n_goal), .n_partial(n_partial), .n_nopath(n_nopath), .n_words(n_words)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls at random with the current phase's probability.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Sends one word. The valid line is only lowered when a gap follows, so that
    // back-to-back words never see two assignments to it in one time step.
    task automatic send_word(gaps_pkg::in_word_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Every field is filled at random first, so that unused bits toggle as well.
    function automatic gaps_pkg::in_word_t noise_word(logic [1:0] cmd);
        gaps_pkg::in_word_t w;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        w = raw[$bits(gaps_pkg::in_word_t)-1:0];
        w.command = cmd;
        return w;
    endfunction

    task automatic load_tile(int x, int y, bit pass_bit);
        gaps_pkg::in_word_t w;
        w = noise_word(gaps_pkg::CMD_LOAD);
        w.tile_x = 6'(x);
        w.tile_y = 6'(y);
        w.tile_open = pass_bit;
        send_word(w);
    endtask

    task automatic search(int sx, int sy, int gx, int gy);
        gaps_pkg::in_word_t w;
        w = noise_word(gaps_pkg::CMD_SEARCH);
        w.start_col = 6'(sx);
        w.start_row = 6'(sy);
        w.goal_col = 6'(gx);
        w.goal_row = 6'(gy);
        send_word(w);
    endtask

    task automatic read_waypoint(int idx);
        gaps_pkg::in_word_t w;
        w = noise_word(gaps_pkg::CMD_READ);
        w.waypoint_index = 12'(idx);
        send_word(w);
    endtask

    // Register writes happen only once the block has answered everything.
    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (40) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // One phase of random traffic on a small grid: the map is filled first, mostly
    // passable, then loads, searches, waypoint reads and the spare code are mixed.
    task automatic run_phase(int cols, int rows, int budget, int idle, int stall, int words);
        int pick;
        write_reg(gaps_pkg::REG_COLS, 13'(cols));
        write_reg(gaps_pkg::REG_ROWS, 13'(rows));
        write_reg(gaps_pkg::REG_BUDGET, 13'(budget));
        idle_pct = idle;
        stall_pct = stall;
        for (int y = 0; y < rows; y++)
            for (int x = 0; x < cols; x++)
                load_tile(x, y, $urandom_range(99) < 75);
        for (int i = 0; i < words; i++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if ($urandom_range(9) == 0)
                    load_tile($urandom_range(63), $urandom_range(63), $urandom_range(1));
                else
                    load_tile($urandom_range(cols - 1), $urandom_range(rows - 1),
                              $urandom_range(99) < 70);
            end else if (pick < 61) begin
                if ($urandom_range(9) == 0)
                    search($urandom_range(63), $urandom_range(63),
                           $urandom_range(63), $urandom_range(63));
                else
                    search($urandom_range(cols - 1), $urandom_range(rows - 1),
                           $urandom_range(cols - 1), $urandom_range(rows - 1));
            end else if (pick < 95) begin
                if ($urandom_range(9) == 0) read_waypoint($urandom_range(4095));
                else read_waypoint($urandom_range(cols + rows + 2));
            end else begin
                send_word(noise_word(CMD_NOP));
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = gaps_pkg::REG_COLS;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part on the reset grid of 64 by 64.
        search(5, 5, 5, 5);           // start equals goal
        search(0, 0, 63, 63);         // goal still blocked after reset
        load_tile(63, 63, 1'b1);
        load_tile(62, 62, 1'b1);
        load_tile(62, 63, 1'b1);
        load_tile(63, 62, 1'b1);
        read_waypoint(0);             // empty path
        send_word(noise_word(CMD_NOP));
        write_reg(gaps_pkg::REG_BUDGET, 13'd0);
        search(62, 62, 63, 63);       // budget zero
        write_reg(gaps_pkg::REG_BUDGET, 13'd3);
        search(62, 62, 63, 63);       // diagonal straight to the far corner
        read_waypoint(0);
        read_waypoint(1);
        read_waypoint(4095);
        load_tile(62, 63, 1'b0);      // corner cut now forbidden
        search(62, 62, 63, 63);
        read_waypoint(1);
        // Clamping of the dimension registers at both ends, and the spare index.
        write_reg(gaps_pkg::REG_COLS, 13'd0);
        write_reg(gaps_pkg::REG_ROWS, 13'd127);
        write_reg(REG_SPARE, 13'h1fff);
        write_reg(gaps_pkg::REG_BUDGET, 13'd4096);
        load_tile(0, 0, 1'b1);
        load_tile(0, 1, 1'b0);
        search(0, 1, 0, 0);           // blocked start is still expanded
        search(3, 0, 0, 0);           // start off the grid
        search(0, 0, 1, 0);           // goal off the grid
        write_reg(gaps_pkg::REG_COLS, 13'd64);
        write_reg(gaps_pkg::REG_ROWS, 13'd64);

        run_phase(8, 8, 4096, 0, 0, 175);
        run_phase(6, 5, 20, 82, 0, 175);
        run_phase(7, 9, 4096, 0, 82, 175);
        run_phase(4, 4, 4096, 38, 38, 175);

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (50) @(posedge aclk);
        $display("Covered %0d result words: %0d searches reached the goal, %0d partial,",
                 n_words, n_goal, n_partial);
        $display("%0d no path, over grids from 1 by 64 to 64 by 64 with budgets 0 to 4096.",
                 n_nopath);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, searches included.
    initial begin
        #200_000_000;
        $display("Timeout with %0d words still expected", pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
